FILE: hw/rtl/gauss_seidel_linear_solver_unit_assert.svh
// assertion macros shared by the solver rtl
`ifndef GAUSS_SEIDEL_LINEAR_SOLVER_UNIT_ASSERT_SVH
`define GAUSS_SEIDEL_LINEAR_SOLVER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GSL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// next-cycle implication, checked out of reset
`define GSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

FILE: hw/rtl/gsl_pkg.sv
`default_nettype none

package gsl_pkg;

  // input op codes
  localparam logic [1:0] OP_COEF  = 2'd0;
  localparam logic [1:0] OP_RHS   = 2'd1;
  localparam logic [1:0] OP_SOLVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_CONV   = 2'd0;
  localparam logic [1:0] ST_NOTDOM = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_TOL   = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  // controls broadcast from the sequencer to every row cell
  typedef struct packed {
    logic        load_coef;
    logic        load_rhs;
    logic        dom_clear;
    logic        dom_step;
    logic        mac_clear;
    logic        mac_step;
    logic        res_store;
    logic        x_write;
    logic [31:0] data;
  } cell_ctl_t;

  // word handed from one cell to the next: dominance flag and running max |r|
  typedef struct packed {
    logic        ok;
    logic [31:0] mag;
  } chain_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gsl_cell.sv
`default_nettype none

module gsl_cell #(
  parameter int IDX          = 0,
  parameter int MAX_UNKNOWNS = 8,
  parameter int FRAC_BITS    = 16,
  localparam int CW          = $clog2(MAX_UNKNOWNS)
) (
  input  wire                      clk,
  input  wire                      rst,
  input  gsl_pkg::cell_ctl_t       ctl,
  input  wire                      sel,
  input  wire                      active,
  input  wire  [CW-1:0]            col,
  input  wire  signed [31:0]       x_in,
  input  gsl_pkg::chain_t          chain_in,
  output gsl_pkg::chain_t          chain_out,
  output logic signed [31:0]       diag,
  output logic signed [31:0]       rhs,
  output logic signed [31:0]       est,
  output logic signed [31:0]       resid
);
  import gsl_pkg::*;

  localparam int ACC_W = 68 - FRAC_BITS;
  localparam int OFW   = 33 + CW;
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  logic signed [31:0]      coef [MAX_UNKNOWNS];
  logic [OFW-1:0]          off;
  logic signed [63:0]      prod;
  logic                    prod_v;
  logic signed [ACC_W-1:0] acc;

  logic signed [31:0] cur;
  logic [31:0]        cur_mag, diag_mag, r_mag;
  logic [63:0]        p_mag, p_rnd;
  logic signed [ACC_W-1:0] p_term;
  logic               own_ok;
  logic signed [31:0] acc_sat;

  assign diag = coef[IDX];
  assign cur  = coef[col];

  // magnitudes
  always_comb begin
    cur_mag  = cur[31] ? 32'(-cur) : 32'(cur);
    diag_mag = diag[31] ? 32'(-diag) : 32'(diag);
    r_mag    = resid[31] ? 32'(-resid) : 32'(resid);
    own_ok   = (diag_mag != 32'd0) && (off < OFW'(diag_mag));
  end

  // product rounded to nearest, ties away from zero
  always_comb begin
    p_mag  = prod[63] ? 64'(-prod) : 64'(prod);
    p_rnd  = (p_mag + HALF) >> FRAC_BITS;
    p_term = prod[63] ? -$signed(ACC_W'(p_rnd)) : $signed(ACC_W'(p_rnd));
  end

  // saturate the accumulated residual to 32 bits
  always_comb begin
    if (acc > ACC_W'(64'sh7fffffff)) begin
      acc_sat = 32'sh7fffffff;
    end else if (acc < -$signed(ACC_W'(64'h80000000))) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc[31:0];
    end
  end

  // row storage and estimate
  always_ff @(posedge clk) begin
    if (ctl.load_coef && sel) begin
      coef[col] <= ctl.data;
    end
    if (ctl.load_rhs && sel) begin
      rhs <= ctl.data;
    end
    if (ctl.x_write && sel) begin
      est <= ctl.data;
    end
    if (ctl.res_store) begin
      resid <= acc_sat;
    end
  end

  // off-diagonal magnitude sum, one column a cycle
  always_ff @(posedge clk) begin
    if (ctl.dom_clear) begin
      off <= '0;
    end else if (ctl.dom_step && (int'(col) != IDX)) begin
      off <= off + OFW'(cur_mag);
    end
  end

  // multiply-accumulate, one column a cycle, product registered
  always_ff @(posedge clk) begin
    prod <= cur * x_in;
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.mac_step;
    end
    if (ctl.mac_clear) begin
      acc <= -$signed(ACC_W'(rhs));
    end else if (prod_v) begin
      acc <= acc + p_term;
    end
  end

  // hand dominance flag and running max to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_out.ok  <= 1'b1;
      chain_out.mag <= '0;
    end else begin
      chain_out.ok  <= chain_in.ok && (own_ok || !active);
      chain_out.mag <= (active && (r_mag > chain_in.mag)) ? r_mag : chain_in.mag;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gsl_divider.sv
`default_nettype none

module gsl_divider #(
  parameter int FRAC_BITS = 16,
  localparam int NB       = 33 + FRAC_BITS,
  localparam int NCW      = $clog2(NB + 1)
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire  signed [31+FRAC_BITS:0] num,
  input  wire  signed [31:0]          den,
  output logic                        done,
  output logic signed [31:0]          quo
);
  import gsl_pkg::*;

  logic [NB-1:0]  qr;
  logic [31:0]    rem;
  logic [31:0]    dv;
  logic           neg;
  logic           busy;
  logic [NCW-1:0] cnt;

  logic [31+FRAC_BITS:0] n_mag;
  logic [31:0]           d_mag;
  logic [32:0]           rem_sh;
  logic [32:0]           rem_sub;
  logic                  fits;

  always_comb begin
    n_mag   = num[31+FRAC_BITS] ? (32+FRAC_BITS)'(-num) : (32+FRAC_BITS)'(num);
    d_mag   = den[31] ? 32'(-den) : 32'(den);
    rem_sh  = {rem, qr[NB-1]};
    fits    = rem_sh >= {1'b0, dv};
    rem_sub = rem_sh - {1'b0, dv};
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dv   <= d_mag;
        neg  <= num[31+FRAC_BITS] ^ den[31];
        // bias by half the divisor for round to nearest
        qr   <= NB'(n_mag) + NB'(d_mag >> 1);
      end else if (busy) begin
        rem <= fits ? rem_sub[31:0] : rem_sh[31:0];
        qr  <= {qr[NB-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == NCW'(NB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // signed, saturated quotient
  always_comb begin
    if (neg) begin
      quo = (qr[NB-1:31] != '0) ? 32'sh80000000 : -$signed(qr[31:0]);
    end else begin
      quo = (qr[NB-1:31] != '0) ? 32'sh7fffffff : $signed(qr[31:0]);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gauss_seidel_linear_solver_unit.sv
// Gauss-Seidel solver for up to eight unknowns, signed fixed point.
// Input channel (in_valid/in_ready): op 0 loads coefficient (row, col),
// op 1 loads right-hand side entry row, op 2 starts a solve. Loads are taken
// one per cycle. A solve holds in_ready low until its results are delivered.
// Output channel (out_valid/out_ready): one word per unknown, index 0..n-1,
// last set on the final one; a stalled receiver simply holds the word.
// Config channel (cfg_valid/cfg_ready) is always ready: size, tolerance,
// step limit.
// Each row lives in a cell; cells hand the dominance flag and the running
// max |residual| down the chain, so each check waits for the word to pass the last cell.
// A solve checks dominance; if the matrix is dominant it computes a start
// estimate for each row with the shared divider, then alternates residual
// passes and single-row corrections until the residual is within tolerance
// or the step limit is hit, then sends n words at one per cycle while ready.
// Reset (rst, synchronous) restores size 8, tolerance 66, step limit 1000;
// coefficient and right-hand side stores hold nothing valid until loaded.
`default_nettype none

module gauss_seidel_linear_solver_unit #(
  parameter int MAX_UNKNOWNS = 8,
  parameter int FRAC_BITS    = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [1:0]        op,
  input  wire  [2:0]        row,
  input  wire  [2:0]        col,
  input  wire  signed [31:0] value,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [2:0]        index,
  output logic signed [31:0] solution,
  output logic [1:0]        status,
  output logic [15:0]       steps_taken,
  output logic              last,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [1:0]        cfg_index,
  input  wire  [31:0]       cfg_data
);
  import gsl_pkg::*;

  `include "gauss_seidel_linear_solver_unit_assert.svh"

  localparam int CW  = $clog2(MAX_UNKNOWNS);
  localparam int CAP = (MAX_UNKNOWNS < 8) ? MAX_UNKNOWNS : 8;
  localparam int WW  = $clog2(MAX_UNKNOWNS + 3);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DOM   = 4'd1;
  localparam logic [3:0] S_DOMW  = 4'd2;
  localparam logic [3:0] S_DIVI  = 4'd3;
  localparam logic [3:0] S_RES   = 4'd4;
  localparam logic [3:0] S_NORMW = 4'd5;
  localparam logic [3:0] S_CORR  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]    state;
  logic [3:0]    size_in_use;
  logic [15:0]   tolerance;
  logic [15:0]   step_limit;
  logic [CW-1:0] nm1, j, k, ci;
  logic [WW-1:0] wcnt;
  logic [15:0]   steps;
  logic [1:0]    sol_status;
  logic          div_pend, emit_done;

  cell_ctl_t          ctl;
  chain_t             chain_v [MAX_UNKNOWNS];
  chain_t             chain_head;
  logic signed [31:0] diag_v [MAX_UNKNOWNS];
  logic signed [31:0] rhs_v  [MAX_UNKNOWNS];
  logic signed [31:0] x_v    [MAX_UNKNOWNS];
  logic signed [31:0] r_v    [MAX_UNKNOWNS];
  logic [MAX_UNKNOWNS-1:0] sel, active;

  logic          in_acc, div_start, div_done, wait_end, col_ok;
  logic [CW-1:0] col_mux, xrow;
  logic [CW-1:0] nm1_next;
  logic signed [31+FRAC_BITS:0] div_num;
  logic signed [31:0] div_den, quo;
  logic signed [32:0] x_diff;
  logic signed [31:0] x_corr;
  chain_t             chain_last;

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_valid && in_ready;
  assign chain_head = '{ok: 1'b1, mag: 32'd0};
  assign chain_last = chain_v[MAX_UNKNOWNS-1];
  assign wait_end   = (wcnt == WW'(MAX_UNKNOWNS + 2));
  assign col_ok     = (int'(col) < MAX_UNKNOWNS);
  assign col_mux    = (state == S_IDLE) ? CW'(col) : j;
  assign xrow       = (state == S_DIVI) ? k : ci;

  // size clamped into the supported range
  always_comb begin
    if (size_in_use < 4'd2) begin
      nm1_next = CW'(1);
    end else if (int'(size_in_use) > CAP) begin
      nm1_next = CW'(CAP - 1);
    end else begin
      nm1_next = CW'(size_in_use - 4'd1);
    end
  end

  // divider operands and estimate correction
  assign div_start = ((state == S_DIVI) || (state == S_CORR)) && !div_pend;
  assign div_num   = (state == S_DIVI) ? $signed({rhs_v[k], {FRAC_BITS{1'b0}}})
                                       : $signed({r_v[ci], {FRAC_BITS{1'b0}}});
  assign div_den   = (state == S_DIVI) ? diag_v[k] : diag_v[ci];

  always_comb begin
    x_diff = {x_v[ci][31], x_v[ci]} - {quo[31], quo};
    if (x_diff > 33'sh07fffffff) begin
      x_corr = 32'sh7fffffff;
    end else if (x_diff < -33'sh080000000) begin
      x_corr = 32'sh80000000;
    end else begin
      x_corr = x_diff[31:0];
    end
  end

  // cell controls
  always_comb begin
    ctl.load_coef = in_acc && (op == OP_COEF) && col_ok;
    ctl.load_rhs  = in_acc && (op == OP_RHS);
    ctl.dom_clear = in_acc && (op == OP_SOLVE);
    ctl.dom_step  = (state == S_DOM);
    ctl.mac_clear = div_done && (((state == S_DIVI) && (k == nm1)) || (state == S_CORR));
    ctl.mac_step  = (state == S_RES);
    ctl.res_store = (state == S_NORMW) && (wcnt == WW'(1));
    ctl.x_write   = div_done && ((state == S_DIVI) || (state == S_CORR));
    if (state == S_IDLE) begin
      ctl.data = value;
    end else if (state == S_DIVI) begin
      ctl.data = quo;
    end else begin
      ctl.data = x_corr;
    end
  end

  // row cells
  for (genvar g = 0; g < MAX_UNKNOWNS; g++) begin : g_cell
    assign sel[g]    = (state == S_IDLE) ? (int'(row) == g) : (int'(xrow) == g);
    assign active[g] = (int'(nm1) >= g);
    if (g == 0) begin : g_head
      gsl_cell #(.IDX(g), .MAX_UNKNOWNS(MAX_UNKNOWNS), .FRAC_BITS(FRAC_BITS)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .sel(sel[g]), .active(active[g]),
        .col(col_mux), .x_in(x_v[j]), .chain_in(chain_head), .chain_out(chain_v[g]),
        .diag(diag_v[g]), .rhs(rhs_v[g]), .est(x_v[g]), .resid(r_v[g])
      );
    end else begin : g_body
      gsl_cell #(.IDX(g), .MAX_UNKNOWNS(MAX_UNKNOWNS), .FRAC_BITS(FRAC_BITS)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .sel(sel[g]), .active(active[g]),
        .col(col_mux), .x_in(x_v[j]), .chain_in(chain_v[g-1]), .chain_out(chain_v[g]),
        .diag(diag_v[g]), .rhs(rhs_v[g]), .est(x_v[g]), .resid(r_v[g])
      );
    end
  end

  // shared divider
  gsl_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= 4'd8;
      tolerance   <= 16'd66;
      step_limit  <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE:  size_in_use <= cfg_data[3:0];
        CFG_TOL:   tolerance   <= cfg_data[15:0];
        CFG_LIMIT: step_limit  <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // solve sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_pend  <= 1'b0;
      out_valid <= 1'b0;
      steps     <= '0;
    end else begin
      if (div_start) begin
        div_pend <= 1'b1;
      end else if (div_done) begin
        div_pend <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (op == OP_SOLVE)) begin
            nm1   <= nm1_next;
            j     <= '0;
            ci    <= '0;
            steps <= '0;
            state <= S_DOM;
          end
        end
        S_DOM: begin
          j <= j + 1'b1;
          if (j == nm1) begin
            wcnt  <= '0;
            state <= S_DOMW;
          end
        end
        S_DOMW: begin
          wcnt <= wcnt + 1'b1;
          if (wait_end) begin
            k <= '0;
            if (!chain_last.ok) begin
              sol_status <= ST_NOTDOM;
              emit_done  <= 1'b0;
              state      <= S_OUT;
            end else begin
              state <= S_DIVI;
            end
          end
        end
        S_DIVI: begin
          if (div_done) begin
            k <= k + 1'b1;
            if (k == nm1) begin
              j     <= '0;
              state <= S_RES;
            end
          end
        end
        S_RES: begin
          j <= j + 1'b1;
          if (j == nm1) begin
            wcnt  <= '0;
            state <= S_NORMW;
          end
        end
        S_NORMW: begin
          wcnt <= wcnt + 1'b1;
          if (wait_end) begin
            k         <= '0;
            emit_done <= 1'b0;
            if (chain_last.mag <= {16'd0, tolerance}) begin
              sol_status <= ST_CONV;
              state      <= S_OUT;
            end else if (steps >= step_limit) begin
              sol_status <= ST_LIMIT;
              state      <= S_OUT;
            end else begin
              state <= S_CORR;
            end
          end
        end
        S_CORR: begin
          if (div_done) begin
            steps <= steps + 16'd1;
            ci    <= (ci == nm1) ? '0 : ci + 1'b1;
            j     <= '0;
            state <= S_RES;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            if (!emit_done) begin
              out_valid   <= 1'b1;
              index       <= 3'(k);
              solution    <= (sol_status == ST_NOTDOM) ? 32'sd0 : x_v[k];
              status      <= sol_status;
              steps_taken <= steps;
              last        <= (k == nm1);
              if (k == nm1) begin
                emit_done <= 1'b1;
              end else begin
                k <= k + 1'b1;
              end
            end else begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `GSL_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
  `GSL_ASSERT_NEXT(a_last_ends, out_valid && out_ready && last, !out_valid)
  `GSL_ASSERT_NOW(a_notdom_zero, out_valid && (status == ST_NOTDOM), solution == 32'sd0)

endmodule

`default_nettype wire

FILE: tb/sv/gauss_seidel_linear_solver_unit_tb.sv
`default_nettype none

module gauss_seidel_linear_solver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsl_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 120;
  localparam int FRAC = 16;

  typedef struct {
    logic [2:0]        idx;
    logic signed [31:0] sol;
    logic [1:0]        st;
    logic [15:0]       steps;
    logic              lst;
  } sol_word_t;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    bit          notdom;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic [2:0] row = '0;
  logic [2:0] col = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] index;
  logic signed [31:0] solution;
  logic [1:0] status;
  logic [15:0] steps_taken;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gauss_seidel_linear_solver_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row(row), .col(col), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .index(index), .solution(solution), .status(status),
    .steps_taken(steps_taken), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the solver state
  int a_m [64];
  int b_m [8];
  int x_m [8];
  int r_m [8];
  int unsigned n_cfg = 8;
  int unsigned tol_cfg = 66;
  int unsigned lim_cfg = 1000;

  sol_word_t solution_q [$];
  int errors = 0;
  int cycles = 0;
  int idle_mode = 0;
  int words_sent = 0;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // rounded divide, ties away from zero, saturated
  function automatic int qdiv(longint num, longint den);
    longint m, d, q;
    m = mag(num);
    d = mag(den);
    q = (m + d / 2) / d;
    if ((num < 0) != (den < 0)) begin
      if (q >= 64'sd2147483648) return 32'h80000000;
      return int'(-q);
    end
    if (q > 64'sd2147483647) return 32'h7fffffff;
    return int'(q);
  endfunction

  function automatic longint qmul(int a, int b);
    longint p, m, r;
    p = longint'(a) * longint'(b);
    m = mag(p);
    r = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    return (p < 0) ? -r : r;
  endfunction

  function automatic longint refresh_residual(int unsigned n);
    longint norm, s;
    norm = 0;
    for (int i = 0; i < n; i++) begin
      s = -longint'(b_m[i]);
      for (int j = 0; j < n; j++) s += qmul(a_m[i*8+j], x_m[j]);
      r_m[i] = sat32(s);
      if (mag(longint'(r_m[i])) > norm) norm = mag(longint'(r_m[i]));
    end
    return norm;
  endfunction

  function automatic bit is_dominant(int unsigned n);
    longint diag, off;
    for (int i = 0; i < n; i++) begin
      diag = mag(longint'(a_m[i*8+i]));
      off = 0;
      if (diag == 0) return 0;
      for (int j = 0; j < n; j++) if (j != i) off += mag(longint'(a_m[i*8+j]));
      if (off >= diag) return 0;
    end
    return 1;
  endfunction

  function automatic int unsigned used_size();
    if (n_cfg < 2) return 2;
    if (n_cfg > 8) return 8;
    return n_cfg;
  endfunction

  // update the shadow and queue the solution words an accepted word causes
  function automatic void predict_solve(logic [1:0] o, logic [2:0] r, logic [2:0] c,
                                        logic [31:0] v, bit notdom);
    int unsigned n, steps, i;
    logic [1:0] st;
    longint norm;
    sol_word_t w;
    if (o == OP_COEF) begin
      a_m[r*8+c] = v;
      return;
    end
    if (o == OP_RHS) begin
      b_m[r] = v;
      return;
    end
    if (o != OP_SOLVE) return;
    n = used_size();
    steps = 0;
    if (!is_dominant(n)) begin
      st = ST_NOTDOM;
    end else begin
      for (int k = 0; k < n; k++)
        x_m[k] = qdiv(longint'(b_m[k]) * 65536, longint'(a_m[k*8+k]));
      norm = refresh_residual(n);
      st = ST_CONV;
      while (norm > longint'(tol_cfg)) begin
        if (steps >= lim_cfg) begin
          st = ST_LIMIT;
          break;
        end
        i = steps % n;
        x_m[i] = sat32(longint'(x_m[i]) -
                       longint'(qdiv(longint'(r_m[i]) * 65536, longint'(a_m[i*8+i]))));
        steps++;
        norm = refresh_residual(n);
      end
    end
    for (int k = 0; k < n; k++) begin
      w.idx = 3'(k);
      w.lst = (k + 1 == n);
      if (notdom) begin
        // typed by hand: a rejected matrix gives zeros and no steps
        w.sol = 0;
        w.st = ST_NOTDOM;
        w.steps = 0;
      end else begin
        w.sol = (st == ST_NOTDOM) ? 0 : x_m[k];
        w.st = st;
        w.steps = steps[15:0];
      end
      solution_q.push_back(w);
    end
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 13;
      1: return $urandom_range(99) < 50;
      default: return 0;
    endcase
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    case (idle_mode)
      0: out_ready <= ($urandom_range(99) >= 50);
      1: out_ready <= ($urandom_range(99) >= 13);
      default: out_ready <= 1'b1;
    endcase
  end

  // compare each delivered word with the oldest expectation
  always @(posedge clk) begin
    sol_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected word index %0d solution %h", $time, index, solution);
        errors++;
      end else begin
        w = solution_q.pop_front();
        if (index !== w.idx || solution !== w.sol || status !== w.st ||
            steps_taken !== w.steps || last !== w.lst) begin
          $display("%0t: mismatch expected idx %0d sol %h st %0d steps %0d last %0b",
                   $time, w.idx, w.sol, w.st, w.steps, w.lst);
          $display("%0t:          actual   idx %0d sol %h st %0d steps %0d last %0b",
                   $time, index, solution, status, steps_taken, last);
          errors++;
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("gauss_seidel_linear_solver_unit_tb NOT OK");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic [1:0] o, logic [2:0] r, logic [2:0] c,
                           logic [31:0] v, bit notdom);
    while (sender_idles()) @(negedge clk);
    in_valid = 1'b1;
    op = o;
    row = r;
    col = c;
    value = v;
    do @(posedge clk); while (!in_ready);
    predict_solve(o, r, c, v, notdom);
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (solution_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    drain();
    repeat (20) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SIZE:  n_cfg = data[3:0];
      CFG_TOL:   tol_cfg = data[15:0];
      CFG_LIMIT: lim_cfg = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] signed_pick(int unsigned m);
    int v;
    v = int'($urandom_range(m));
    return $urandom_range(1) ? -v : v;
  endfunction

  // well-formed system: dominant matrix with random content, then a solve
  task automatic load_and_solve(int unsigned n);
    int d;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (r == c) begin
          d = int'($urandom_range(16 << 16, 8 << 16));
          send_word(OP_COEF, 3'(r), 3'(c), $urandom_range(1) ? -d : d, 0);
        end else begin
          send_word(OP_COEF, 3'(r), 3'(c), signed_pick(32768), 0);
        end
      end
      send_word(OP_RHS, 3'(r), 3'($urandom), signed_pick(20 << 16), 0);
    end
    send_word(OP_SOLVE, 3'($urandom), 3'($urandom), $urandom, 0);
  endtask

  task automatic random_phase(int unsigned n, int unsigned quota);
    int unsigned stop;
    stop = words_sent + quota;
    while (words_sent < stop) begin
      if ($urandom_range(5) == 0) begin
        // noise: stray loads and the spare op code
        repeat ($urandom_range(3, 1))
          send_word($urandom_range(1) ? OP_SPARE : 2'($urandom_range(1)),
                    3'($urandom), 3'($urandom), $urandom, 0);
      end else begin
        load_and_solve(n);
      end
    end
  endtask

  stim_row_t directed [$] = '{
    '{OP_SOLVE, 3'd0, 3'd0, 32'h0,        1'b0},
    '{OP_COEF,  3'd0, 3'd0, 32'h0,        1'b0},
    '{OP_SOLVE, 3'd0, 3'd0, 32'h0,        1'b1},
    '{OP_COEF,  3'd0, 3'd0, 32'h7fffffff, 1'b0},
    '{OP_RHS,   3'd0, 3'd5, 32'h80000000, 1'b0},
    '{OP_RHS,   3'd7, 3'd7, 32'h7fffffff, 1'b0},
    '{OP_COEF,  3'd7, 3'd7, 32'h80000000, 1'b0},
    '{OP_SOLVE, 3'd7, 3'd7, 32'hffffffff, 1'b0},
    '{OP_SPARE, 3'd7, 3'd7, 32'hffffffff, 1'b0},
    '{OP_COEF,  3'd3, 3'd4, 32'h00030000, 1'b0},
    '{OP_SOLVE, 3'd0, 3'd0, 32'h0,        1'b1},
    '{OP_COEF,  3'd3, 3'd4, 32'h0,        1'b0},
    '{OP_COEF,  3'd3, 3'd3, 32'hfffe0000, 1'b0},
    '{OP_SOLVE, 3'd0, 3'd0, 32'h0,        1'b0},
    '{OP_COEF,  3'd1, 3'd0, 32'h00010000, 1'b0},
    '{OP_COEF,  3'd0, 3'd1, 32'h00008000, 1'b0},
    '{OP_COEF,  3'd0, 3'd0, 32'h00040000, 1'b0},
    '{OP_RHS,   3'd1, 3'd0, 32'hffff0000, 1'b0},
    '{OP_SOLVE, 3'd0, 3'd0, 32'h0,        1'b0}
  };

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill every entry once so no solve reads an unwritten one
    idle_mode = 0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++)
        send_word(OP_COEF, 3'(r), 3'(c), (r == c) ? 32'h20000 : 32'h0, 0);
      send_word(OP_RHS, 3'(r), 3'd0, (r + 1) << 16, 0);
    end

    // directed cases at reset settings
    foreach (directed[k])
      send_word(directed[k].op, directed[k].row, directed[k].col,
                directed[k].value, directed[k].notdom);

    // oversize clamps to eight, loosest tolerance, largest step limit
    write_reg(CFG_SIZE, 32'hf);
    write_reg(CFG_TOL, 32'h5a5a_ffff);
    write_reg(CFG_LIMIT, 32'hffff);
    send_word(OP_SOLVE, 3'd0, 3'd0, 32'h0, 0);

    // smallest system, exact tolerance, one correction at most
    write_reg(CFG_SIZE, 32'h2);
    write_reg(CFG_TOL, 32'h0);
    write_reg(CFG_LIMIT, 32'hffff_0001);
    random_phase(2, 25);

    // size zero clamps to two; sender holds off until all words are back
    idle_mode = 1;
    write_reg(CFG_SIZE, 32'hfffffff0);
    write_reg(CFG_TOL, 32'd300);
    write_reg(CFG_LIMIT, 32'd30);
    random_phase(2, 12);
    drain();
    random_phase(2, 12);

    idle_mode = 2;
    write_reg(CFG_SIZE, 32'd5);
    write_reg(CFG_TOL, 32'd66);
    write_reg(CFG_LIMIT, 32'd50);
    random_phase(5, 25);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("gauss_seidel_linear_solver_unit_tb OK");
    end else begin
      $display("gauss_seidel_linear_solver_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
